FILE: hdl/spq_pkg.sv
// spq_pkg: shared types, constants and command/status structs for the
// sorted priority queue; used by spq_ctrl, spq_datapath and the top level
`default_nettype none

package spq_pkg;

    // queue storage depth, a power of two (ring addressing wraps by truncation)
    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int CAP_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DELETED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } in_word_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] removed_priority;
        logic [COUNT_W-1:0]       entry_count;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take_item;   // latch the accepted input word
        logic set_full;    // refuse insert
        logic set_empty;   // refuse delete
        logic ins_begin;   // hole at tail, read last entry
        logic shift_step;  // move one entry down or drop the new one in
        logic place_item;  // write new entry at hole
        logic del_begin;   // read head entry
        logic del_finish;  // pop head entry
        logic out_load;    // move result to output register
    } spq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic op_delete;   // opcode of the word at the input
        logic full;        // no room for another entry
        logic empty;       // no entries stored
        logic shift_more;  // entry above the hole has lower priority
        logic hole_one;    // hole sits right below the head
        logic out_free;    // output register can take a result
    } spq_stat_t;

endpackage

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// spq_ctrl: operation sequencer for the sorted priority queue
// depends on spq_pkg for command/status structs
`default_nettype none

module spq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t      cmd
);
    import spq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_PLACE  = 5'b00100,
        S_DREAD  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // input is taken only between operations
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_item = 1'b1;
                    if (stat.op_delete)
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            cmd.del_begin = 1'b1;
                            state_next    = S_DREAD;
                        end
                    end
                    else
                    begin
                        if (stat.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_RESULT;
                        end
                        else
                        begin
                            cmd.ins_begin = 1'b1;
                            state_next    = stat.empty ? S_PLACE : S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (!stat.shift_more)
                    state_next = S_RESULT;
                else if (stat.hole_one)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place_item = 1'b1;
                state_next     = S_RESULT;
            end
            S_DREAD:
            begin
                cmd.del_finish = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hdl/spq_datapath.sv
// spq_datapath: ring-buffer entry store, head/count/capacity registers,
// result and output registers; depends on spq_pkg
`default_nettype none

module spq_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spq_pkg::in_word_t     in_word,
    output spq_pkg::out_word_t         out_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_data,
    input  wire spq_pkg::spq_cmd_t     cmd,
    output spq_pkg::spq_stat_t         stat
);
    import spq_pkg::*;

    // entry store, sorted by descending priority starting at head
    logic signed [DATA_W-1:0] prio_mem [DEPTH];
    logic signed [DATA_W-1:0] val_mem  [DEPTH];

    logic signed [DATA_W-1:0] rd_prio_reg;
    logic signed [DATA_W-1:0] rd_val_reg;

    logic signed [DATA_W-1:0] item_value_reg;
    logic signed [DATA_W-1:0] item_priority_reg;

    logic [ADDR_W-1:0] head_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  hole_reg;
    logic [CAP_W-1:0]  capacity_reg;

    status_t                  res_status_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic signed [DATA_W-1:0] res_priority_reg;

    out_word_t out_reg;
    logic      out_valid_reg;

    logic                     rd_en;
    logic [CNT_W-1:0]         rd_log;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_prio;
    logic signed [DATA_W-1:0] wr_val;
    logic                     lower;
    logic                     item_done;

    // entry above the hole yields to the new one
    assign lower = (rd_prio_reg < item_priority_reg);

    // status to controller
    assign stat.op_delete  = (in_word.opcode == OP_DELETE);
    assign stat.full       = (32'(occ_reg) >= 32'(capacity_reg)) ||
                             (32'(occ_reg) >= 32'(DEPTH));
    assign stat.empty      = (occ_reg == '0);
    assign stat.shift_more = lower;
    assign stat.hole_one   = (hole_reg == CNT_W'(1));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // read port address, logical index from head
    always_comb
    begin
        rd_en  = 1'b0;
        rd_log = '0;
        if (cmd.ins_begin)
        begin
            rd_en  = 1'b1;
            rd_log = occ_reg - CNT_W'(1);
        end
        else if (cmd.shift_step)
        begin
            rd_en  = 1'b1;
            rd_log = hole_reg - CNT_W'(2);
        end
        else if (cmd.del_begin)
        begin
            rd_en  = 1'b1;
            rd_log = '0;
        end
    end
    assign rd_addr = head_reg + rd_log[ADDR_W-1:0];

    // write port: shifted entry or new entry at the hole
    assign item_done = cmd.place_item || (cmd.shift_step && !lower);
    assign wr_en     = cmd.place_item || cmd.shift_step;
    assign wr_addr   = head_reg + hole_reg[ADDR_W-1:0];
    assign wr_prio   = item_done ? item_priority_reg : rd_prio_reg;
    assign wr_val    = item_done ? item_value_reg    : rd_val_reg;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
            val_mem[wr_addr]  <= wr_val;
        end
        if (rd_en)
        begin
            rd_prio_reg <= prio_mem[rd_addr];
            rd_val_reg  <= val_mem[rd_addr];
        end
    end

    // item and hole registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_value_reg    <= in_word.item_value;
            item_priority_reg <= in_word.item_priority;
        end
        if (cmd.ins_begin)
            hole_reg <= occ_reg;
        else if (cmd.shift_step && lower)
            hole_reg <= hole_reg - CNT_W'(1);
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.set_full)
        begin
            res_status_reg   <= ST_FULL;
            res_value_reg    <= '0;
            res_priority_reg <= '0;
        end
        else if (cmd.set_empty)
        begin
            res_status_reg   <= ST_EMPTY;
            res_value_reg    <= '0;
            res_priority_reg <= '0;
        end
        else if (item_done)
        begin
            res_status_reg   <= ST_INSERTED;
            res_value_reg    <= '0;
            res_priority_reg <= '0;
        end
        else if (cmd.del_finish)
        begin
            res_status_reg   <= ST_DELETED;
            res_value_reg    <= rd_val_reg;
            res_priority_reg <= rd_prio_reg;
        end
    end

    // head, count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            occ_reg      <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_data;
            if (item_done)
                occ_reg <= occ_reg + CNT_W'(1);
            else if (cmd.del_finish)
            begin
                occ_reg  <= occ_reg - CNT_W'(1);
                head_reg <= head_reg + ADDR_W'(1);
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status           <= res_status_reg;
            out_reg.removed_value    <= res_value_reg;
            out_reg.removed_priority <= res_priority_reg;
            out_reg.entry_count      <= COUNT_W'(occ_reg);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// sorted_priority_queue: one word at a time; full/empty refusal, delete and
// insert (moving entries down the store, one memory port pair, one entry per
// cycle) each register a result; the next word is taken the cycle after the
// result enters the output register, even while it waits.
// reset: queue empty, capacity 128; store contents undefined, no clearing pass
// depends on spq_pkg, spq_ctrl, spq_datapath
`default_nettype none

module sorted_priority_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire spq_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output spq_pkg::out_word_t     out_word,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_data
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    // sequencer
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and registers
    spq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
